// ----- hw/rtl/pes_pkg.sv -----
// Shared types, constants and colour tables for the palette emphasis scaler.
`timescale 1ns / 1ps
package pes_pkg;

	localparam int unsigned CODE_W     = 9;
	localparam int unsigned IDX_W      = 6;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned FACTOR_W   = 11;
	localparam int unsigned PROD_W     = CHAN_W + FACTOR_W;
	localparam int unsigned ADDR_W     = 18;
	localparam int unsigned NUM_CHAN   = 3;

	localparam int unsigned DEF_LINE_WIDTH   = 256;
	localparam int unsigned DEF_FRAME_HEIGHT = 240;
	localparam int unsigned DEF_QUEUE_DEPTH  = 2;

	// Divide by 1000 as a multiply by ceil(2^32 / 1000) and a shift of 32; exact for
	// dividends below 2^18, which covers every unsaturated product.
	localparam int unsigned DIV_IN_W    = 18;
	localparam int unsigned RECIP_W     = 23;
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned RECIP_PROD_W = DIV_IN_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(4294968);
	localparam logic [PROD_W-1:0]  SAT_LIMIT = PROD_W'(256000);

	typedef logic [CHAN_W-1:0] chan_t;
	typedef chan_t [NUM_CHAN-1:0] rgb_t;          // [2] red, [1] green, [0] blue
	typedef logic [NUM_CHAN-1:0][FACTOR_W-1:0] factor_t;

	localparam chan_t CHAN_MAX = 8'hFF;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		rgb_t              colour;
	} entry_t;

	function automatic rgb_t base_colour(input logic [IDX_W-1:0] idx);
		rgb_t c;
		case (idx)
			6'd0:  c = {8'd84,  8'd84,  8'd84};
			6'd1:  c = {8'd0,   8'd30,  8'd116};
			6'd2:  c = {8'd8,   8'd16,  8'd144};
			6'd3:  c = {8'd48,  8'd0,   8'd136};
			6'd4:  c = {8'd68,  8'd0,   8'd100};
			6'd5:  c = {8'd92,  8'd0,   8'd48};
			6'd6:  c = {8'd84,  8'd4,   8'd0};
			6'd7:  c = {8'd60,  8'd24,  8'd0};
			6'd8:  c = {8'd32,  8'd42,  8'd0};
			6'd9:  c = {8'd8,   8'd58,  8'd0};
			6'd10: c = {8'd0,   8'd64,  8'd0};
			6'd11: c = {8'd0,   8'd60,  8'd0};
			6'd12: c = {8'd0,   8'd50,  8'd60};
			6'd16: c = {8'd152, 8'd150, 8'd152};
			6'd17: c = {8'd8,   8'd76,  8'd196};
			6'd18: c = {8'd48,  8'd50,  8'd236};
			6'd19: c = {8'd92,  8'd30,  8'd228};
			6'd20: c = {8'd136, 8'd20,  8'd176};
			6'd21: c = {8'd160, 8'd20,  8'd100};
			6'd22: c = {8'd152, 8'd34,  8'd32};
			6'd23: c = {8'd120, 8'd60,  8'd0};
			6'd24: c = {8'd84,  8'd90,  8'd0};
			6'd25: c = {8'd40,  8'd114, 8'd0};
			6'd26: c = {8'd8,   8'd124, 8'd0};
			6'd27: c = {8'd0,   8'd118, 8'd40};
			6'd28: c = {8'd0,   8'd102, 8'd120};
			6'd32: c = {8'd236, 8'd238, 8'd236};
			6'd33: c = {8'd76,  8'd154, 8'd236};
			6'd34: c = {8'd120, 8'd124, 8'd236};
			6'd35: c = {8'd176, 8'd98,  8'd236};
			6'd36: c = {8'd228, 8'd84,  8'd236};
			6'd37: c = {8'd236, 8'd88,  8'd180};
			6'd38: c = {8'd236, 8'd106, 8'd100};
			6'd39: c = {8'd212, 8'd136, 8'd32};
			6'd40: c = {8'd160, 8'd170, 8'd0};
			6'd41: c = {8'd116, 8'd196, 8'd0};
			6'd42: c = {8'd76,  8'd208, 8'd32};
			6'd43: c = {8'd56,  8'd204, 8'd108};
			6'd44: c = {8'd56,  8'd180, 8'd204};
			6'd45: c = {8'd60,  8'd60,  8'd60};
			6'd48: c = {8'd236, 8'd238, 8'd236};
			6'd49: c = {8'd168, 8'd204, 8'd236};
			6'd50: c = {8'd188, 8'd188, 8'd236};
			6'd51: c = {8'd212, 8'd178, 8'd236};
			6'd52: c = {8'd236, 8'd174, 8'd236};
			6'd53: c = {8'd236, 8'd174, 8'd212};
			6'd54: c = {8'd236, 8'd180, 8'd176};
			6'd55: c = {8'd228, 8'd196, 8'd144};
			6'd56: c = {8'd204, 8'd210, 8'd120};
			6'd57: c = {8'd180, 8'd222, 8'd120};
			6'd58: c = {8'd168, 8'd226, 8'd144};
			6'd59: c = {8'd152, 8'd226, 8'd180};
			6'd60: c = {8'd160, 8'd214, 8'd228};
			6'd61: c = {8'd160, 8'd162, 8'd160};
			default: c = '0;
		endcase
		return c;
	endfunction

	// Emphasis factors in thousandths, red/green/blue.
	function automatic factor_t emphasis_factor(input logic [CODE_W-IDX_W-1:0] sel);
		factor_t f;
		case (sel)
			3'd0:    f = {11'd1000, 11'd1000, 11'd1000};
			3'd1:    f = {11'd1239, 11'd915,  11'd743};
			3'd2:    f = {11'd794,  11'd1086, 11'd882};
			3'd3:    f = {11'd1019, 11'd980,  11'd653};
			3'd4:    f = {11'd905,  11'd1026, 11'd1277};
			3'd5:    f = {11'd1023, 11'd908,  11'd979};
			3'd6:    f = {11'd741,  11'd987,  11'd1001};
			3'd7:    f = {11'd750,  11'd750,  11'd750};
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

// ----- hw/rtl/pes_pixel_if.sv -----
// Pixel input channel: valid/ready with the pixel code and frame start flag.
`timescale 1ns / 1ps
interface pes_pixel_if;
	import pes_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] pixel_code;
	logic              frame_start;

	modport source (output valid, output pixel_code, output frame_start, input ready);
	modport sink   (input valid, input pixel_code, input frame_start, output ready);
endinterface

// ----- hw/rtl/pes_write_if.sv -----
// Framebuffer write channel: valid/ready with address, colour and run marker.
`timescale 1ns / 1ps
interface pes_write_if;
	import pes_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] write_address;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic              last_of_run;

	modport source (output valid, output write_address, output red, output green,
		output blue, output last_of_run, input ready);
	modport sink   (input valid, input write_address, input red, input green,
		input blue, input last_of_run, output ready);
endinterface

// ----- hw/rtl/pes_front.sv -----
// Front end: position counters, palette lookup, emphasis multiply and divide.
`timescale 1ns / 1ps
module pes_front #(
	parameter int unsigned LINE_WIDTH   = pes_pkg::DEF_LINE_WIDTH,
	parameter int unsigned FRAME_HEIGHT = pes_pkg::DEF_FRAME_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	pes_pixel_if.sink        pixel,
	output logic             push_valid,
	output pes_pkg::entry_t  push_entry,
	input  logic             push_ready
);
	import pes_pkg::*;

	localparam int unsigned COL_W = $clog2(LINE_WIDTH);
	localparam int unsigned ROW_W = $clog2(FRAME_HEIGHT);
	localparam int unsigned BLOCK_STRIDE = 4 * LINE_WIDTH;

	logic [COL_W-1:0] col_q, col_cur;
	logic [ROW_W-1:0] row_q, row_cur;
	logic             fire, adv_s2;

	rgb_t    base_c;
	factor_t fac;

	logic                          valid_s1, valid_s2;
	logic [ADDR_W-1:0]             addr_s1, addr_s2;
	logic [NUM_CHAN-1:0][PROD_W-1:0] prod_s1;
	logic [NUM_CHAN-1:0][RECIP_PROD_W-1:0] recip;
	chan_t [NUM_CHAN-1:0]          quot_s2;
	logic [NUM_CHAN-1:0]           sat_s2;

	assign adv_s2      = !valid_s2 || push_ready;
	assign pixel.ready = !valid_s1 || adv_s2;
	assign fire        = pixel.valid && pixel.ready;

	// frame start forces the top-left corner before this pixel
	assign col_cur = pixel.frame_start ? '0 : col_q;
	assign row_cur = pixel.frame_start ? '0 : row_q;

	assign base_c = base_colour(pixel.pixel_code[IDX_W-1:0]);
	assign fac    = emphasis_factor(pixel.pixel_code[CODE_W-1:IDX_W]);

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			recip[c] = RECIP_PROD_W'(prod_s1[c][DIV_IN_W-1:0]) * RECIP_PROD_W'(RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				if (col_cur == COL_W'(LINE_WIDTH - 1)) begin
					col_q <= '0;
					if (row_cur == ROW_W'(FRAME_HEIGHT - 1)) begin
						row_q <= '0;
					end else begin
						row_q <= row_cur + 1'b1;
					end
				end else begin
					col_q <= col_cur + 1'b1;
					row_q <= row_cur;
				end
			end
			if (pixel.ready) begin
				valid_s1 <= pixel.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			addr_s1 <= ADDR_W'(ADDR_W'(row_cur) * ADDR_W'(BLOCK_STRIDE))
				+ ADDR_W'({col_cur, 1'b0});
			for (int c = 0; c < NUM_CHAN; c++) begin
				prod_s1[c] <= PROD_W'(base_c[c]) * PROD_W'(fac[c]);
			end
		end
		if (adv_s2 && valid_s1) begin
			addr_s2 <= addr_s1;
			for (int c = 0; c < NUM_CHAN; c++) begin
				sat_s2[c]  <= prod_s1[c] >= SAT_LIMIT;
				quot_s2[c] <= recip[c][RECIP_SHIFT +: CHAN_W];
			end
		end
	end

	assign push_valid      = valid_s2;
	assign push_entry.addr = addr_s2;
	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			push_entry.colour[c] = sat_s2[c] ? CHAN_MAX : quot_s2[c];
		end
	end
endmodule

// ----- hw/rtl/pes_queue.sv -----
// Short FIFO of finished pixels between the front end and the write sequencer.
`timescale 1ns / 1ps
module pes_queue #(
	parameter int unsigned DEPTH = pes_pkg::DEF_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  pes_pkg::entry_t push_entry,
	output logic            push_ready,
	output logic            pop_valid,
	output pes_pkg::entry_t pop_entry,
	input  logic            pop_ready
);
	import pes_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t             slots [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = slots[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_q] <= push_entry;
		end
	end
endmodule

// ----- hw/rtl/pes_back.sv -----
// Write sequencer: emits the four words of each 2x2 block in order.
`timescale 1ns / 1ps
module pes_back #(
	parameter int unsigned LINE_WIDTH = pes_pkg::DEF_LINE_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	input  pes_pkg::entry_t pop_entry,
	output logic            pop_ready,
	pes_write_if.source     fb_write
);
	import pes_pkg::*;

	localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(2 * LINE_WIDTH);

	typedef enum logic [1:0] {
		PH_TOP_LEFT,
		PH_TOP_RIGHT,
		PH_BOT_LEFT,
		PH_BOT_RIGHT
	} phase_t;

	phase_t            phase_q;
	logic              busy_q;
	entry_t            cur_q;
	logic              fire;
	logic [ADDR_W-1:0] offset;

	assign fire      = fb_write.valid && fb_write.ready;
	assign pop_ready = !busy_q || (fire && phase_q == PH_BOT_RIGHT);

	always_comb begin
		case (phase_q)
			PH_TOP_LEFT:  offset = '0;
			PH_TOP_RIGHT: offset = ADDR_W'(1);
			PH_BOT_LEFT:  offset = ROW_STRIDE;
			PH_BOT_RIGHT: offset = ROW_STRIDE + ADDR_W'(1);
			default:      offset = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_TOP_LEFT;
		end else begin
			if (pop_ready) begin
				busy_q  <= pop_valid;
				phase_q <= PH_TOP_LEFT;
			end else if (fire) begin
				case (phase_q)
					PH_TOP_LEFT:  phase_q <= PH_TOP_RIGHT;
					PH_TOP_RIGHT: phase_q <= PH_BOT_LEFT;
					PH_BOT_LEFT:  phase_q <= PH_BOT_RIGHT;
					default:      phase_q <= PH_TOP_LEFT;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			cur_q <= pop_entry;
		end
	end

	assign fb_write.valid         = busy_q;
	assign fb_write.write_address = cur_q.addr + offset;
	assign fb_write.red           = cur_q.colour[2];
	assign fb_write.green         = cur_q.colour[1];
	assign fb_write.blue          = cur_q.colour[0];
	assign fb_write.last_of_run   = phase_q == PH_BOT_RIGHT;
endmodule

// ----- hw/rtl/nes_palette_emphasis_2x_scaler.sv -----
// Top level: palette lookup with colour emphasis and 2x2 framebuffer writes.
// Path: an accepted pixel word passes the product and divide stages, the queue and
// the sequencer; its four words follow on consecutive cycles when the sink is ready.
// Rate: the single write port carries four words per pixel and so sets the pixel rate;
// the front end accepts a word per cycle until the queue fills.
// Reset: asynchronous, clears the position counters, pipeline valids and queue.
`timescale 1ns / 1ps
module nes_palette_emphasis_2x_scaler #(
	parameter int unsigned LINE_WIDTH   = pes_pkg::DEF_LINE_WIDTH,
	parameter int unsigned FRAME_HEIGHT = pes_pkg::DEF_FRAME_HEIGHT,
	parameter int unsigned QUEUE_DEPTH  = pes_pkg::DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	pes_pixel_if.sink   pixel,
	pes_write_if.source fb_write
);
	import pes_pkg::*;

	// Front to queue: finished colour and the block's top-left address.
	logic   push_valid, push_ready;
	entry_t push_entry;

	// Queue to sequencer.
	logic   pop_valid, pop_ready;
	entry_t pop_entry;

	// Front end: track position, look up the base colour, apply emphasis over two
	// stages (product, then divide by 1000 with saturation folded in at the output).
	pes_front #(
		.LINE_WIDTH   (LINE_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	// Decouple the front end from the sequencer so each may stall on its own.
	pes_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	// Back end: hold one pixel and step through its four framebuffer words; pick up
	// the next pixel on the same edge that the last word is taken.
	pes_back #(
		.LINE_WIDTH (LINE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop_ready (pop_ready),
		.fb_write  (fb_write)
	);
endmodule
